// ===== rtl/rthc_pkg.sv =====
// Package: item types, fixed-point constants and divider step for the RGB to HSV core
`timescale 1ns / 1ps
`default_nettype none
package rthc_pkg;

  localparam int CHANNEL_BITS      = 16;
  localparam int HUE_FRACTION_BITS = 6;
  localparam int HUE_BITS          = 15;
  localparam int ALPHA_BITS        = 16;

  localparam int HUE_SCALE  = 1 << HUE_FRACTION_BITS;
  localparam int SIXTY      = 60 * HUE_SCALE;
  localparam int FULL_TURN  = 360 * HUE_SCALE;
  localparam int HUE_Q_BITS = $clog2(SIXTY + 1);
  localparam int DIV_STEPS  = (CHANNEL_BITS + 1 > HUE_Q_BITS) ? CHANNEL_BITS + 1 : HUE_Q_BITS;
  localparam int NUM_BITS   = CHANNEL_BITS + DIV_STEPS;
  localparam int HUE_W      = HUE_BITS + 1;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [ALPHA_BITS-1:0]   alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue_out;
    logic [CHANNEL_BITS-1:0] saturation_out;
    logic [CHANNEL_BITS-1:0] value_out;
    logic [ALPHA_BITS-1:0]   alpha_out;
  } out_item_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] mag;
    logic                    neg;
    logic [1:0]              sector;
    logic [CHANNEL_BITS-1:0] rng;
    logic [CHANNEL_BITS-1:0] mx;
    logic [ALPHA_BITS-1:0]   alpha;
  } cls_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] hrem;
    logic [DIV_STEPS-1:0]    hlow;
    logic [CHANNEL_BITS-1:0] srem;
    logic [DIV_STEPS-1:0]    slow;
    logic                    neg;
    logic [1:0]              sector;
    logic [CHANNEL_BITS-1:0] rng;
    logic [CHANNEL_BITS-1:0] mx;
    logic [ALPHA_BITS-1:0]   alpha;
  } dv_t;

  function automatic dv_t div_step(dv_t s);
    logic [CHANNEL_BITS:0] hx;
    logic [CHANNEL_BITS:0] sx;
    logic [CHANNEL_BITS:0] hd;
    logic [CHANNEL_BITS:0] sd;
    logic                  hge;
    logic                  sge;
    dv_t                   o;
    hx  = {s.hrem, s.hlow[DIV_STEPS-1]};
    sx  = {s.srem, s.slow[DIV_STEPS-1]};
    hd  = hx - {1'b0, s.rng};
    sd  = sx - {1'b0, s.mx};
    hge = (hx >= {1'b0, s.rng});
    sge = (sx >= {1'b0, s.mx});
    o      = s;
    o.hrem = hge ? hd[CHANNEL_BITS-1:0] : hx[CHANNEL_BITS-1:0];
    o.srem = sge ? sd[CHANNEL_BITS-1:0] : sx[CHANNEL_BITS-1:0];
    o.hlow = {s.hlow[DIV_STEPS-2:0], hge};
    o.slow = {s.slow[DIV_STEPS-2:0], sge};
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rthc_front.sv =====
// Front stage: accept a pixel, find max, min, dominant sector and hue difference
`timescale 1ns / 1ps
`default_nettype none
module rthc_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic push,
  input  rthc_pkg::in_item_t item,
  output logic               full,
  output logic               cls_v,
  output rthc_pkg::cls_t     cls,
  input  wire                logic cls_rdy
);
  import rthc_pkg::*;

  logic                    f_v_r;
  cls_t                    f_r;
  cls_t                    c_nxt;
  logic [CHANNEL_BITS-1:0] r, g, b, p, m, mn;
  logic                    adv;

  assign adv = !f_v_r || cls_rdy;
  assign full  = !adv;
  assign cls_v = f_v_r;
  assign cls   = f_r;

  always_comb begin
    r = item.red_in;
    g = item.green_in;
    b = item.blue_in;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (r >= g && r >= b) begin
      c_nxt.sector = SEC_RED;
      c_nxt.mx = r;
      p = g;
      m = b;
    end else if (g >= b) begin
      c_nxt.sector = SEC_GREEN;
      c_nxt.mx = g;
      p = b;
      m = r;
    end else begin
      c_nxt.sector = SEC_BLUE;
      c_nxt.mx = b;
      p = r;
      m = g;
    end
    c_nxt.neg   = (p < m);
    c_nxt.mag   = (p < m) ? m - p : p - m;
    c_nxt.rng   = c_nxt.mx - mn;
    c_nxt.alpha = item.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && adv) begin
      f_r <= c_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rthc_queue.sv =====
// Two-entry queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none
module rthc_queue (
  input  wire            logic clk,
  input  wire            logic rst_n,
  input  wire            logic wr_v,
  input  rthc_pkg::cls_t wr_d,
  output logic           wr_rdy,
  output logic           rd_v,
  output rthc_pkg::cls_t rd_d,
  input  wire            logic rd_rdy
);
  import rthc_pkg::*;

  cls_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_rdy = (cnt_r != 2'd2);
  assign rd_v   = (cnt_r != 2'd0);
  assign rd_d   = ent_r[rp_r];
  assign do_wr  = wr_v && wr_rdy;
  assign do_rd  = rd_v && rd_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rthc_back.sv =====
// Back pipeline: scale, two bit-per-stage dividers, hue and saturation finish, output register
`timescale 1ns / 1ps
`default_nettype none
module rthc_back (
  input  wire             logic clk,
  input  wire             logic rst_n,
  input  wire             logic in_v,
  input  rthc_pkg::cls_t  in_d,
  output logic            in_rdy,
  output logic            out_empty,
  output rthc_pkg::out_item_t out_item,
  input  wire             logic out_pop
);
  import rthc_pkg::*;

  logic [DIV_STEPS:0] v_r;
  dv_t                st_r [DIV_STEPS+1];
  logic               out_v_r;
  out_item_t          out_r;
  logic               adv;
  dv_t                init;
  logic [NUM_BITS-1:0] hn;
  logic [NUM_BITS-1:0] sn;
  out_item_t          fin;
  dv_t                l;
  logic [HUE_W-1:0]   q;
  logic [HUE_W-1:0]   hq;
  logic [HUE_W-1:0]   base;
  logic [HUE_W-1:0]   h;

  assign adv       = !out_v_r || out_pop;
  assign in_rdy    = adv;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  always_comb begin
    hn = NUM_BITS'(in_d.mag) * NUM_BITS'(SIXTY);
    sn = NUM_BITS'({in_d.rng, {CHANNEL_BITS{1'b0}}});
    init.hrem   = hn[NUM_BITS-1:DIV_STEPS];
    init.hlow   = hn[DIV_STEPS-1:0];
    init.srem   = sn[NUM_BITS-1:DIV_STEPS];
    init.slow   = sn[DIV_STEPS-1:0];
    init.neg    = in_d.neg;
    init.sector = in_d.sector;
    init.rng    = in_d.rng;
    init.mx     = in_d.mx;
    init.alpha  = in_d.alpha;
  end

  always_comb begin
    l  = st_r[DIV_STEPS];
    q  = HUE_W'(l.hlow);
    hq = q + HUE_W'(|l.hrem);
    case (l.sector)
      SEC_RED:   base = l.neg ? HUE_W'(FULL_TURN) : '0;
      SEC_GREEN: base = HUE_W'(120 * HUE_SCALE);
      SEC_BLUE:  base = HUE_W'(240 * HUE_SCALE);
      default:   base = '0;
    endcase
    h = l.neg ? base - hq : base + q;
    if (h >= HUE_W'(FULL_TURN)) h = h - HUE_W'(FULL_TURN);
    if (l.rng == '0) h = '0;
    fin.hue_out = h[HUE_BITS-1:0];
    if (l.mx == '0) begin
      fin.saturation_out = '0;
    end else if (|l.slow[DIV_STEPS-1:CHANNEL_BITS]) begin
      fin.saturation_out = '1;
    end else begin
      fin.saturation_out = l.slow[CHANNEL_BITS-1:0];
    end
    fin.value_out = l.mx;
    fin.alpha_out = l.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[DIV_STEPS-1:0], in_v};
      out_v_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= init;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      out_r <= fin;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_core.sv =====
// Top level of the RGB to HSV converter: front classifier, queue, divider pipeline
//
// Input channel: drive in_item (red, green, blue Q0.16 and alpha) and raise
// in_push; the item is taken at a clock edge where in_push is high and in_full
// is low. Result channel: while out_empty is low, out_item holds the oldest
// result (hue in 1/64 degree, saturation, value, alpha); it is taken at an
// edge where out_pop is high.
// From the accepting edge to out_empty falling, an item passes the front
// register, the queue, one scaling stage, 17 divider stages (one quotient
// bit each for hue and saturation) and the output register.
// Throughput is one item per cycle while the receiver keeps popping; the divider pipeline sets the latency.
// When the receiver stops popping, the back pipeline holds, the two-entry
// queue and the front register fill, then in_full rises. Nothing is lost.
// Synchronous reset (rst_n low) empties every stage: out_empty goes high and
// in_full low.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter_core (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic in_push,
  input  rthc_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  output rthc_pkg::out_item_t out_item,
  input  wire                 logic out_pop
);
  import rthc_pkg::*;

  logic cls_v, cls_rdy, q_v, q_rdy;
  cls_t cls, q_d;

  rthc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .item(in_item), .full(in_full),
    .cls_v(cls_v), .cls(cls), .cls_rdy(cls_rdy)
  );

  rthc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_v(cls_v), .wr_d(cls), .wr_rdy(cls_rdy),
    .rd_v(q_v), .rd_d(q_d), .rd_rdy(q_rdy)
  );

  rthc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_v(q_v), .in_d(q_d), .in_rdy(q_rdy),
    .out_empty(out_empty), .out_item(out_item), .out_pop(out_pop)
  );

  assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("reset must empty the block");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.hue_out < HUE_BITS'(FULL_TURN))
    else $error("hue beyond full turn");

  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.value_out == '0 |->
      out_item.saturation_out == '0 && out_item.hue_out == '0)
    else $error("black pixel must give zero hue and saturation");

endmodule
`default_nettype wire
